>>> hdl/snv_pkg.sv
package snv_pkg;

    localparam int WIRE_W     = 4;
    localparam int CH_W       = 5;
    localparam int FAIL_W     = 17;
    localparam int SEEN_W     = 8;
    localparam logic [CH_W-1:0] CH_RESET = 5'd2;

    // one stored compare-exchange: upper wire in the high nibble
    typedef struct packed {
        logic [WIRE_W-1:0] upper;
        logic [WIRE_W-1:0] lower;
    } pair_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EVAL,
        ST_DONE
    } snv_state_t;

endpackage

>>> hdl/sorting_network_zero_one_verifier.sv
// Flow: a plain comparator is stored; a last one with a latched error or bad channel
// count goes straight to the result, else every stored pair is range-checked, then each
// of the 2^N zero-one vectors runs through all C comparators (N wires) before the result
// loads, waiting on any result stall; one shared compare-exchange unit, one store read port.
// Throughput: one comparator per cycle while loading; no input is taken during evaluation.
// Reset: rst_n async, active low; clears count, error latch, output valid; channel_count 2.
module sorting_network_zero_one_verifier
    import snv_pkg::*;
#(
    parameter int MAX_CHANNELS    = 16,
    parameter int MAX_COMPARATORS = 128
)
(
    input  logic              clk,
    input  logic              rst_n,

    // configuration write channel (channel_count)
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CH_W-1:0]   cfg_data,

    // comparator input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [WIRE_W-1:0] lower_wire,
    input  logic [WIRE_W-1:0] upper_wire,
    input  logic              last_comparator,

    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [FAIL_W-1:0] failure_count,
    output logic [FAIL_W-1:0] vectors_tested,
    output logic [SEEN_W-1:0] comparators_seen,
    output logic              network_error
);

    localparam int W     = MAX_CHANNELS;
    localparam int CNT_W = $clog2(MAX_COMPARATORS + 1);
    localparam int AW    = (MAX_COMPARATORS > 1) ? $clog2(MAX_COMPARATORS) : 1;
    localparam int FW    = MAX_CHANNELS + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COMPARATORS);

    snv_state_t        state_reg, state_next;
    logic [CH_W-1:0]   n_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              latch_reg, latch_next;
    logic              err_reg, err_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              plast_reg, plast_next;
    logic [W-1:0]      w_reg, w_next;
    logic [W-1:0]      v_reg, v_next;
    logic [FW-1:0]     fails_reg, fails_next;

    logic              out_valid_reg, out_valid_next;
    logic [FAIL_W-1:0] fail_out_reg, fail_out_next;
    logic [FAIL_W-1:0] tested_out_reg, tested_out_next;
    logic [SEEN_W-1:0] seen_out_reg, seen_out_next;
    logic              err_out_reg, err_out_next;

    logic              in_take;
    logic              store_wr;
    pair_t             in_pair;
    pair_t             rd_pair;
    logic [W-1:0]      w_cx;
    logic              rd_ok;
    logic [CNT_W-1:0]  cnt_m1;
    logic              idx_at_end;
    logic [W-1:0]      adj_mask;
    logic [W-1:0]      last_vec;
    logic [FAIL_W-1:0] tested_val;
    logic              unsorted;
    logic              n_bad;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign in_pair   = '{upper: upper_wire, lower: lower_wire};
    assign store_wr  = in_take && (count_reg < CNT_MAX);

    assign cnt_m1     = count_reg - CNT_W'(1);
    assign idx_at_end = (idx_reg == cnt_m1);
    assign n_bad      = (n_reg < CH_RESET) || (int'(n_reg) > MAX_CHANNELS);

    // wire masks for the channel count in force: adjacent pairs to test, all-ones last vector; and 2^N tested
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            adj_mask[i] = (i + 1 < int'(n_reg));
            last_vec[i] = (i < int'(n_reg));
        end
        for (int j = 0; j < FAIL_W; j++)
        begin
            tested_val[j] = (int'(n_reg) == j);
        end
    end

    snv_store #(
        .DEPTH (MAX_COMPARATORS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_pair),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_pair)
    );

    // the one shared compare-exchange unit, also used for the range check
    snv_cx_unit #(
        .WIDTH (W)
    ) u_cx (
        .w_in       (w_reg),
        .pair       (rd_pair),
        .chan_count (n_reg),
        .w_out      (w_cx),
        .pair_ok    (rd_ok)
    );

    assign unsorted = |(w_cx & ~(w_cx >> 1) & adj_mask);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= CH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            n_reg <= cfg_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            latch_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            latch_reg     <= latch_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        err_reg        <= err_next;
        idx_reg        <= idx_next;
        plast_reg      <= plast_next;
        w_reg          <= w_next;
        v_reg          <= v_next;
        fails_reg      <= fails_next;
        fail_out_reg   <= fail_out_next;
        tested_out_reg <= tested_out_next;
        seen_out_reg   <= seen_out_next;
        err_out_reg    <= err_out_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        latch_next      = latch_reg;
        err_next        = err_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        plast_next      = plast_reg;
        w_next          = w_reg;
        v_next          = v_reg;
        fails_next      = fails_reg;
        fail_out_next   = fail_out_reg;
        tested_out_next = tested_out_reg;
        seen_out_next   = seen_out_reg;
        err_out_next    = err_out_reg;
        out_valid_next  = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    // store the pair, or flag overflow and drop it
                    if (count_reg < CNT_MAX)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        latch_next = 1'b1;
                    end
                    if (last_comparator)
                    begin
                        err_next = latch_next || n_bad;
                        idx_next = '0;
                        state_next = (latch_next || n_bad) ? ST_DONE : ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                // stream every stored pair once through the range check
                if (idx_reg < count_reg)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                    plast_next = idx_at_end;
                end
                if (pend_reg)
                begin
                    err_next = err_reg || !rd_ok;
                    if (plast_reg)
                    begin
                        if (err_reg || !rd_ok)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_EVAL;
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            w_next     = '0;
                            v_next     = '0;
                            fails_next = '0;
                        end
                    end
                end
            end

            ST_EVAL:
            begin
                // issue reads continuously, wrapping at the end of the network
                idx_next   = idx_at_end ? '0 : idx_reg + CNT_W'(1);
                pend_next  = 1'b1;
                plast_next = idx_at_end;
                if (pend_reg)
                begin
                    if (plast_reg)
                    begin
                        fails_next = fails_reg + FW'(unsorted);
                        if (v_reg == last_vec)
                        begin
                            state_next = ST_DONE;
                            pend_next  = 1'b0;
                        end
                        else
                        begin
                            v_next = v_reg + W'(1);
                            w_next = v_reg + W'(1);
                        end
                    end
                    else
                    begin
                        w_next = w_cx;
                    end
                end
            end

            ST_DONE:
            begin
                // load the result once the output register is free, then clear the store
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    fail_out_next   = err_reg ? '0 : FAIL_W'(fails_reg);
                    tested_out_next = err_reg ? '0 : tested_val;
                    seen_out_next   = SEEN_W'(count_reg);
                    err_out_next    = err_reg;
                    count_next      = '0;
                    latch_next      = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign failure_count    = fail_out_reg;
    assign vectors_tested   = tested_out_reg;
    assign comparators_seen = seen_out_reg;
    assign network_error    = err_out_reg;

`ifndef SYNTHESIS
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && network_error |-> failure_count == '0 && vectors_tested == '0)
        else $error("rejected network reported nonzero counts");

    a_fail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !network_error && vectors_tested != '0 |-> failure_count <= vectors_tested)
        else $error("failure count exceeds vectors tested");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("store count beyond capacity");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_comparator |=> in_stall)
        else $error("input not stalled after last comparator");
`endif

endmodule

>>> hdl/snv_store.sv
module snv_store
    import snv_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  pair_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output pair_t         rd_data
);

    pair_t mem [DEPTH];
    pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/snv_cx_unit.sv
module snv_cx_unit
    import snv_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic [WIDTH-1:0] w_in,
    input  pair_t            pair,
    input  logic [CH_W-1:0]  chan_count,
    output logic [WIDTH-1:0] w_out,
    output logic             pair_ok
);

    logic bit_lo;
    logic bit_hi;
    logic swap;

    // pick the two wires
    always_comb
    begin
        bit_lo = 1'b0;
        bit_hi = 1'b0;
        for (int i = 0; i < WIDTH; i++)
        begin
            bit_lo = bit_lo | (w_in[i] & (int'(pair.lower) == i));
            bit_hi = bit_hi | (w_in[i] & (int'(pair.upper) == i));
        end
    end

    assign swap = bit_lo & ~bit_hi;

    // AND to the lower wire, OR to the upper wire
    always_comb
    begin
        for (int i = 0; i < WIDTH; i++)
        begin
            if (swap && int'(pair.lower) == i)
            begin
                w_out[i] = 1'b0;
            end
            else if (swap && int'(pair.upper) == i)
            begin
                w_out[i] = 1'b1;
            end
            else
            begin
                w_out[i] = w_in[i];
            end
        end
    end

    assign pair_ok = (pair.lower < pair.upper) && ({1'b0, pair.upper} < chan_count);

endmodule
